// ===== rtl/core/pna_pkg.sv =====
// pna_pkg: shared types, widths, register codes and helpers for the
// periodic neighbor address unit. No dependencies.
`timescale 1ns / 1ps

package pna_pkg;

    localparam int unsigned MAX_DIM_DEF = 1024;
    localparam int unsigned STEP_BITS   = 4;
    localparam int unsigned COORD_W     = 10;
    localparam int unsigned SIZE_W      = 11;
    localparam int unsigned SITE_W      = 30;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned DIM_W       = 17;
    localparam int unsigned TGT_W       = SIZE_W + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SIZE_X = 3'd0,
        CFG_SIZE_Y = 3'd1,
        CFG_SIZE_Z = 3'd2,
        CFG_WRAP_X = 3'd3,
        CFG_WRAP_Y = 3'd4,
        CFG_WRAP_Z = 3'd5
    } t_cfg_idx;

    localparam logic [SIZE_W-1:0] SIZE_RST = 11'd64;

    typedef struct packed {
        logic [COORD_W-1:0]          start_x;
        logic [COORD_W-1:0]          start_y;
        logic [COORD_W-1:0]          start_z;
        logic signed [STEP_BITS-1:0] step_x;
        logic signed [STEP_BITS-1:0] step_y;
        logic signed [STEP_BITS-1:0] step_z;
    } t_in;

    typedef struct packed {
        logic               move_ok;
        logic [COORD_W-1:0] dest_x;
        logic [COORD_W-1:0] dest_y;
        logic [COORD_W-1:0] dest_z;
        logic [SITE_W-1:0]  site_number;
    } t_out;

    // first stage result: wrapped target per axis and effective y/z sizes
    typedef struct packed {
        logic              ok;
        logic [SIZE_W-1:0] ux;
        logic [SIZE_W-1:0] uy;
        logic [SIZE_W-1:0] uz;
        logic [SIZE_W-1:0] sy;
        logic [SIZE_W-1:0] sz;
    } t_s1;

    // size register of zero acts as one, above the max dimension clamps to it
    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s,
                                                   input logic [DIM_W-1:0]  m);
        logic [SIZE_W-1:0] r;
        r = s;
        if (s == '0) begin
            r = SIZE_W'(1);
        end else if (DIM_W'(s) > m) begin
            r = m[SIZE_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/pna_axis.sv =====
// pna_axis: one axis of the neighbor target: add step, wrap once when
// periodic, range check. Depends on pna_pkg.
`timescale 1ns / 1ps

module pna_axis import pna_pkg::*; (
    input  logic [COORD_W-1:0]          i_start,
    input  logic signed [STEP_BITS-1:0] i_step,
    input  logic [SIZE_W-1:0]           i_size,
    input  logic                        i_wrap,
    output logic                        o_ok,
    output logic [SIZE_W-1:0]           o_pos
);

    logic signed [TGT_W-1:0] w_tgt;
    logic signed [TGT_W-1:0] w_size;
    logic signed [TGT_W-1:0] w_wrapped;

    assign w_tgt  = $signed({2'b00, i_start}) + TGT_W'(i_step);
    assign w_size = $signed({1'b0, i_size});

    always_comb begin
        w_wrapped = w_tgt;
        if (i_wrap) begin
            if (w_tgt < 0) begin
                w_wrapped = w_tgt + w_size;
            end else if (w_tgt >= w_size) begin
                w_wrapped = w_tgt - w_size;
            end
        end
    end

    assign o_ok  = (w_wrapped >= 0) && (w_wrapped < w_size);
    assign o_pos = w_wrapped[SIZE_W-1:0];

endmodule

// ===== rtl/core/pna_index.sv =====
// pna_index: multiply pipeline for the linear site index x*Y*Z + y*Z + z,
// plus the output register. Depends on pna_pkg.
`timescale 1ns / 1ps

module pna_index import pna_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_s1  i_s1,
    output logic o_valid,
    output t_out o_out
);

    localparam int unsigned PROD_W = 2 * SIZE_W;
    localparam int unsigned XPROD_W = SIZE_W + PROD_W;

    // stage 2: partial products
    logic              r_v2;
    logic              r_ok2;
    logic [SIZE_W-1:0] r_ux2, r_uy2, r_uz2;
    logic [PROD_W-1:0] r_yz2, r_ysz2;

    // stage 3: x term and y/z term
    logic              r_v3;
    logic              r_ok3;
    logic [SIZE_W-1:0] r_ux3, r_uy3, r_uz3;
    logic [SITE_W-1:0] r_xyz3, r_part3;

    logic              r_vo;
    t_out              r_out;

    logic [XPROD_W-1:0] w_xprod;

    assign w_xprod = XPROD_W'(r_ux2) * XPROD_W'(r_yz2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            r_v2 <= i_valid;
            r_v3 <= r_v2;
            r_vo <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ok2  <= i_s1.ok;
        r_ux2  <= i_s1.ux;
        r_uy2  <= i_s1.uy;
        r_uz2  <= i_s1.uz;
        r_yz2  <= PROD_W'(i_s1.sy) * PROD_W'(i_s1.sz);
        r_ysz2 <= PROD_W'(i_s1.uy) * PROD_W'(i_s1.sz);

        r_ok3   <= r_ok2;
        r_ux3   <= r_ux2;
        r_uy3   <= r_uy2;
        r_uz3   <= r_uz2;
        r_xyz3  <= w_xprod[SITE_W-1:0];
        r_part3 <= SITE_W'(r_ysz2) + SITE_W'(r_uz2);

        // zero every field of a rejected move
        r_out.move_ok     <= r_ok3;
        r_out.dest_x      <= r_ok3 ? r_ux3[COORD_W-1:0] : '0;
        r_out.dest_y      <= r_ok3 ? r_uy3[COORD_W-1:0] : '0;
        r_out.dest_z      <= r_ok3 ? r_uz3[COORD_W-1:0] : '0;
        r_out.site_number <= r_ok3 ? (r_xyz3 + r_part3) : '0;
    end

    assign o_valid = r_vo;
    assign o_out   = r_out;

endmodule

// ===== rtl/core/periodic_neighbor_address_unit.sv =====
// Periodic neighbor address unit: an accepted start passes four registered stages before the
// o_valid strobe; one transaction per cycle, busy stays low.
// Stage 1 wraps and checks each axis, stages 2-3 form the index products,
// stage 4 is the output register. Receiver cannot stall; each result shows
// for one cycle. Synchronous reset clears the valid pipeline and loads sizes
// of 64 with periodic wrap on all axes. Depends on pna_pkg, pna_axis, pna_index.
`timescale 1ns / 1ps

module periodic_neighbor_address_unit import pna_pkg::*; #(
    parameter int unsigned MAX_DIM = MAX_DIM_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  t_in                  i_in,
    output logic                 o_valid,
    output t_out                 o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [SIZE_W-1:0]    i_cfg_data
);

    localparam logic [DIM_W-1:0] MaxDim = DIM_W'(MAX_DIM);

    logic [SIZE_W-1:0] r_size_x, r_size_y, r_size_z;
    logic              r_wrap_x, r_wrap_y, r_wrap_z;

    logic [SIZE_W-1:0] w_sx, w_sy, w_sz;
    logic              w_okx, w_oky, w_okz, w_zero;
    logic [SIZE_W-1:0] w_px, w_py, w_pz;
    logic              w_accept;

    logic              r_v1;
    t_s1               r_s1;

    assign o_busy   = 1'b0;
    assign w_accept = i_start && !o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x <= SIZE_RST;
            r_size_y <= SIZE_RST;
            r_size_z <= SIZE_RST;
            r_wrap_x <= 1'b1;
            r_wrap_y <= 1'b1;
            r_wrap_z <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_SIZE_X: r_size_x <= i_cfg_data;
                CFG_SIZE_Y: r_size_y <= i_cfg_data;
                CFG_SIZE_Z: r_size_z <= i_cfg_data;
                CFG_WRAP_X: r_wrap_x <= i_cfg_data[0];
                CFG_WRAP_Y: r_wrap_y <= i_cfg_data[0];
                CFG_WRAP_Z: r_wrap_z <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign w_sx = eff_size(r_size_x, MaxDim);
    assign w_sy = eff_size(r_size_y, MaxDim);
    assign w_sz = eff_size(r_size_z, MaxDim);

    pna_axis u_axis_x (
        .i_start (i_in.start_x),
        .i_step  (i_in.step_x),
        .i_size  (w_sx),
        .i_wrap  (r_wrap_x),
        .o_ok    (w_okx),
        .o_pos   (w_px)
    );

    pna_axis u_axis_y (
        .i_start (i_in.start_y),
        .i_step  (i_in.step_y),
        .i_size  (w_sy),
        .i_wrap  (r_wrap_y),
        .o_ok    (w_oky),
        .o_pos   (w_py)
    );

    pna_axis u_axis_z (
        .i_start (i_in.start_z),
        .i_step  (i_in.step_z),
        .i_size  (w_sz),
        .i_wrap  (r_wrap_z),
        .o_ok    (w_okz),
        .o_pos   (w_pz)
    );

    // a move of zero along every axis is not a neighbor
    assign w_zero = (i_in.step_x == '0) && (i_in.step_y == '0) && (i_in.step_z == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1.ok <= w_okx && w_oky && w_okz && !w_zero;
        r_s1.ux <= w_px;
        r_s1.uy <= w_py;
        r_s1.uz <= w_pz;
        r_s1.sy <= w_sy;
        r_s1.sz <= w_sz;
    end

    pna_index u_index (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v1),
        .i_s1    (r_s1),
        .o_valid (o_valid),
        .o_out   (o_out)
    );

    // every strobe traces back to an accepted transaction through the stage pipeline
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(w_accept, 4))
        else $error("result strobe without matching transaction");

    // rejected moves carry all-zero payload
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_out.move_ok) |->
        (o_out.dest_x == '0 && o_out.dest_y == '0 && o_out.dest_z == '0 &&
         o_out.site_number == '0))
        else $error("rejected move with nonzero payload");

    // an accepted move never came from an all-zero step
    a_nonzero_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out.move_ok) |-> !$past(w_zero, 4))
        else $error("zero step reported as valid move");

endmodule
